@@ hdl/epse_pkg.sv @@
// shared types and constants for the encoder period speed estimator
package epse_pkg;

    localparam int RING_DEPTH_DEF = 10;
    localparam int COUNT_BITS_DEF = 16;

    localparam int IV_W    = 16;
    localparam int CPR_W   = 13;
    localparam int RATE_W  = 24;
    localparam int SPEED_W = 24;
    localparam int Q_FRAC  = 8;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 1;

    localparam int TWO_PI_NUM = 628318;
    localparam int TWO_PI_DEN = 100000;

    localparam logic [IV_W-1:0]    IV_MAX    = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

    localparam logic [CPR_W-1:0]  CPR_RESET  = CPR_W'(200);
    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(4000000);

    localparam logic [IDX_W-1:0] CFG_PULSES_PER_REV = 1'b0;
    localparam logic [IDX_W-1:0] CFG_TICK_RATE_HZ   = 1'b1;

    typedef struct packed {
        logic accept;
        logic upd_ring;
        logic mul_a;
        logic mul_b;
        logic div_init;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic capture;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

@@ hdl/epse_ram.sv @@
// generic single write port ram with registered read
module epse_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

@@ hdl/epse_datapath.sv @@
// interval counter, ring with running sum, multipliers and serial divider
module epse_datapath
    import epse_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [CPR_W-1:0]    pulses_per_rev,
    input  logic [RATE_W-1:0]   tick_rate_hz,
    input  logic                edge_req,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [IV_W-1:0]     interval_ticks,
    output logic [SPEED_W-1:0]  speed_q8,
    output logic                speed_saturated,
    output logic                wrapped
);

    localparam int PTR_W   = RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1;
    localparam int SUM_W   = IV_W + $clog2(RING_DEPTH + 1);
    localparam int K_VAL   = TWO_PI_NUM * RING_DEPTH;
    localparam int K_W     = $clog2(K_VAL + 1);
    localparam int PROD_W  = RATE_W + K_W;
    localparam int NUM_W   = PROD_W + Q_FRAC;
    localparam int HI_W    = NUM_W - SPEED_W;
    localparam int P1_W    = CPR_W + SUM_W;
    localparam int DEN_W   = P1_W + $clog2(TWO_PI_DEN + 1);
    localparam int CMP_W   = HI_W > DEN_W ? HI_W : DEN_W;
    localparam int EXT_W   = COUNT_BITS > IV_W ? COUNT_BITS : IV_W;
    localparam int DCNT_W  = $clog2(SPEED_W);

    localparam logic [K_W-1:0]   K_CONST  = K_W'(K_VAL);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    // tick counter state
    logic                  measuring_reg, measuring_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  wrap_reg, wrap_next;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  wrap_inc;
    logic [EXT_W-1:0]      cnt_ext;
    logic [IV_W-1:0]       iv_sat;

    // ring
    logic [RING_DEPTH-1:0] valid_reg, valid_next;
    logic [PTR_W-1:0]      pos_reg, pos_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [IV_W-1:0]       ram_rdata;
    logic [IV_W-1:0]       old_iv;

    // arithmetic
    logic [NUM_W-1:0]      num_reg;
    logic [P1_W-1:0]       p1_reg;
    logic [DEN_W-1:0]      den_reg;
    logic [DEN_W-1:0]      rem_reg, rem_next;
    logic [SPEED_W-1:0]    low_reg, low_next;
    logic [SPEED_W-1:0]    quo_reg, quo_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic                  sat_reg;
    logic [DEN_W:0]        rem_shift;
    logic [DEN_W:0]        rem_sub;

    // result item
    logic [IV_W-1:0]       iv_reg;
    logic                  cap_wrap_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [IV_W-1:0]       out_iv_reg;
    logic [SPEED_W-1:0]    out_speed_reg;
    logic                  out_sat_reg;
    logic                  out_wrap_reg;

    epse_ram #(
        .WIDTH(IV_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.upd_ring),
        .waddr (pos_reg),
        .wdata (iv_reg),
        .re    (cmd.accept),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    assign cnt_inc  = count_reg + COUNT_BITS'(1);
    assign wrap_inc = wrap_reg | (cnt_inc == '0);
    assign cnt_ext  = EXT_W'(cnt_inc);
    assign iv_sat   = (cnt_ext > EXT_W'(IV_MAX)) ? IV_MAX : cnt_ext[IV_W-1:0];
    assign old_iv   = valid_reg[pos_reg] ? ram_rdata : '0;

    assign rem_shift = {rem_reg, low_reg[SPEED_W-1]};
    assign rem_sub   = rem_shift - (DEN_W+1)'(den_reg);

    assign status.capture  = measuring_reg & edge_req;
    assign status.div_last = (dcnt_reg == DCNT_W'(SPEED_W - 1));
    assign status.out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        measuring_next = measuring_reg;
        count_next     = count_reg;
        wrap_next      = wrap_reg;
        if (cmd.accept)
        begin
            if (!measuring_reg)
            begin
                if (edge_req)
                begin
                    count_next     = '0;
                    wrap_next      = 1'b0;
                    measuring_next = 1'b1;
                end
            end
            else
            begin
                count_next = cnt_inc;
                wrap_next  = wrap_inc;
                if (edge_req)
                begin
                    measuring_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        if (cmd.upd_ring)
        begin
            valid_next[pos_reg] = 1'b1;
            pos_next = (pos_reg == PTR_LAST) ? '0 : pos_reg + PTR_W'(1);
            sum_next = sum_reg - SUM_W'(old_iv) + SUM_W'(iv_reg);
        end
    end

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dcnt_next = dcnt_reg;
        if (cmd.div_init)
        begin
            rem_next  = DEN_W'(CMP_W'(num_reg[NUM_W-1:SPEED_W]));
            low_next  = num_reg[SPEED_W-1:0];
            quo_next  = '0;
            dcnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            low_next  = {low_reg[SPEED_W-2:0], 1'b0};
            dcnt_next = dcnt_reg + DCNT_W'(1);
            if (!rem_sub[DEN_W])
            begin
                rem_next = rem_sub[DEN_W-1:0];
                quo_next = {quo_reg[SPEED_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DEN_W-1:0];
                quo_next = {quo_reg[SPEED_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measuring_reg <= 1'b0;
            count_reg     <= '0;
            wrap_reg      <= 1'b0;
            valid_reg     <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            measuring_reg <= measuring_next;
            count_reg     <= count_next;
            wrap_reg      <= wrap_next;
            valid_reg     <= valid_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            dcnt_reg      <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && status.capture)
        begin
            iv_reg       <= iv_sat;
            cap_wrap_reg <= wrap_inc;
        end
        if (cmd.mul_a)
        begin
            num_reg <= {PROD_W'(tick_rate_hz) * PROD_W'(K_CONST), Q_FRAC'(0)};
            p1_reg  <= P1_W'(pulses_per_rev) * P1_W'(sum_reg);
        end
        if (cmd.mul_b)
        begin
            den_reg <= DEN_W'(p1_reg) * DEN_W'(TWO_PI_DEN);
        end
        if (cmd.div_init)
        begin
            // den of zero covers empty sum and zero pulses_per_rev
            sat_reg <= (CMP_W'(num_reg[NUM_W-1:SPEED_W]) >= CMP_W'(den_reg));
        end
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        if (cmd.load_out)
        begin
            out_iv_reg    <= iv_reg;
            out_speed_reg <= sat_reg ? SPEED_MAX : quo_reg;
            out_sat_reg   <= sat_reg;
            out_wrap_reg  <= cap_wrap_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign interval_ticks  = out_iv_reg;
    assign speed_q8        = out_speed_reg;
    assign speed_saturated = out_sat_reg;
    assign wrapped         = out_wrap_reg;

endmodule

@@ hdl/epse_ctrl.sv @@
// sequencing controller for item intake, ring update, multiply and divide
module epse_ctrl
    import epse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RING,
        ST_MUL_A,
        ST_MUL_B,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid & ~in_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.capture)
                begin
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                cmd.upd_ring = 1'b1;
                state_next   = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/encoder_period_speed_estimator_top.sv @@
// top level: configuration registers, controller and datapath
// a tick without a capturing edge leaves the input free; a capturing edge passes
// through ring update, two multiply stages, check, 24-step divider to its result item
// and input is stalled until the result is loaded into the output register
// the divider is restoring; the result waits while a stalled item holds the output
// reset clears counter, ring valid bits, running sum and position; config to defaults
module encoder_period_speed_estimator_top
    import epse_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               edge_req,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [IV_W-1:0]    interval_ticks,
    output logic [SPEED_W-1:0] speed_q8,
    output logic               speed_saturated,
    output logic               wrapped
);

    logic [CPR_W-1:0]  cpr_reg, cpr_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    dp_cmd_t           cmd;
    dp_status_t        status;

    always_comb
    begin
        cpr_next  = cpr_reg;
        rate_next = rate_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PULSES_PER_REV: cpr_next  = cfg_data[CPR_W-1:0];
                CFG_TICK_RATE_HZ:   rate_next = cfg_data[RATE_W-1:0];
                default:            cpr_next  = cpr_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpr_reg  <= CPR_RESET;
            rate_reg <= RATE_RESET;
        end
        else
        begin
            cpr_reg  <= cpr_next;
            rate_reg <= rate_next;
        end
    end

    epse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    epse_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .pulses_per_rev  (cpr_reg),
        .tick_rate_hz    (rate_reg),
        .edge_req        (edge_req),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .interval_ticks  (interval_ticks),
        .speed_q8        (speed_q8),
        .speed_saturated (speed_saturated),
        .wrapped         (wrapped)
    );

endmodule

@@ bench/encoder_period_speed_estimator_top_tb.sv @@
// self-checking testbench for the encoder period speed estimator top level
`timescale 1ns / 1ps

class speed_scoreboard;

    typedef struct packed {
        logic [epse_pkg::IV_W-1:0]    iv;
        logic [epse_pkg::SPEED_W-1:0] speed;
        logic                         sat;
        logic                         wrap;
    } capture_t;

    bit                           measuring;
    bit [epse_pkg::IV_W-1:0]      count;
    bit                           wrap_seen;
    bit [epse_pkg::IV_W-1:0]      ring [epse_pkg::RING_DEPTH_DEF];
    int unsigned                  pos;
    bit [epse_pkg::CPR_W-1:0]     cpr;
    bit [epse_pkg::RATE_W-1:0]    rate;
    capture_t                     expected_q[$];
    int                           errors;
    int                           captures;
    int                           checked;
    int                           sat_seen;
    int                           wrap_count;
    int                           reg_writes;

    function new();
        measuring = 1'b0;
        count = '0;
        wrap_seen = 1'b0;
        foreach (ring[i]) ring[i] = '0;
        pos = 0;
        cpr = epse_pkg::CPR_RESET;
        rate = epse_pkg::RATE_RESET;
        errors = 0;
        captures = 0;
        checked = 0;
        sat_seen = 0;
        wrap_count = 0;
        reg_writes = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void write_reg(logic [epse_pkg::IDX_W-1:0] idx, logic [epse_pkg::CFG_W-1:0] data);
        reg_writes++;
        if (idx == epse_pkg::CFG_PULSES_PER_REV)
            cpr = data[epse_pkg::CPR_W-1:0];
        else if (idx == epse_pkg::CFG_TICK_RATE_HZ)
            rate = data[epse_pkg::RATE_W-1:0];
    endfunction

    function void note_tick(logic edge_bit);
        capture_t          exp_c;
        longint unsigned   sum;
        longint unsigned   num;
        longint unsigned   den;
        longint unsigned   q;
        if (!measuring)
        begin
            if (edge_bit)
            begin
                count = '0;
                wrap_seen = 1'b0;
                measuring = 1'b1;
            end
            return;
        end
        count = count + 1'b1;
        if (count == 0)
            wrap_seen = 1'b1;
        if (!edge_bit)
            return;
        ring[pos] = count;
        pos = (pos + 1 >= epse_pkg::RING_DEPTH_DEF) ? 0 : pos + 1;
        sum = 0;
        foreach (ring[i]) sum += ring[i];
        exp_c.iv = count;
        exp_c.wrap = wrap_seen;
        if (sum == 0 || cpr == 0)
        begin
            exp_c.speed = epse_pkg::SPEED_MAX;
            exp_c.sat = 1'b1;
        end
        else
        begin
            num = epse_pkg::TWO_PI_NUM;
            num = num * rate * epse_pkg::RING_DEPTH_DEF * 256;
            den = epse_pkg::TWO_PI_DEN;
            den = den * cpr * sum;
            q = num / den;
            if (q > epse_pkg::SPEED_MAX)
            begin
                exp_c.speed = epse_pkg::SPEED_MAX;
                exp_c.sat = 1'b1;
            end
            else
            begin
                exp_c.speed = q[epse_pkg::SPEED_W-1:0];
                exp_c.sat = 1'b0;
            end
        end
        if (exp_c.sat)
            sat_seen++;
        if (exp_c.wrap)
            wrap_count++;
        measuring = 1'b0;
        captures++;
        expected_q.push_back(exp_c);
    endfunction

    function void check_result(capture_t got);
        capture_t exp_c;
        if (expected_q.size() == 0)
        begin
            $error("unexpected result item: interval_ticks %0d speed_q8 %0d", got.iv, got.speed);
            errors++;
            return;
        end
        exp_c = expected_q.pop_front();
        checked++;
        if (got.iv !== exp_c.iv)
        begin
            $error("interval_ticks: expected %0d, got %0d", exp_c.iv, got.iv);
            errors++;
        end
        if (got.speed !== exp_c.speed)
        begin
            $error("speed_q8: expected %0d, got %0d", exp_c.speed, got.speed);
            errors++;
        end
        if (got.sat !== exp_c.sat)
        begin
            $error("speed_saturated: expected %0d, got %0d", exp_c.sat, got.sat);
            errors++;
        end
        if (got.wrap !== exp_c.wrap)
        begin
            $error("wrapped: expected %0d, got %0d", exp_c.wrap, got.wrap);
            errors++;
        end
    endfunction

endclass

module encoder_period_speed_estimator_top_tb;
    import epse_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               edge_req;
    logic               out_valid;
    logic               out_stall;
    logic [IV_W-1:0]    interval_ticks;
    logic [SPEED_W-1:0] speed_q8;
    logic               speed_saturated;
    logic               wrapped;

    speed_scoreboard    sb;
    bit                 idle_on;
    int                 ticks_sent;

    encoder_period_speed_estimator_top uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .edge_req        (edge_req),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .interval_ticks  (interval_ticks),
        .speed_q8        (speed_q8),
        .speed_saturated (speed_saturated),
        .wrapped         (wrapped)
    );

    initial clk = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("encoder_period_speed_estimator_top verification failed");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 12);
            out_stall <= (stall_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({interval_ticks, speed_q8, speed_saturated, wrapped});
    end

    task automatic push_tick(input logic e);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid <= 1'b1;
        edge_req <= e;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_tick(e);
        ticks_sent++;
        @(negedge clk);
    endtask

    // start edge, gap empty ticks, capturing edge: interval is gap + 1
    task automatic run_interval(input int gap);
        push_tick(1'b1);
        repeat (gap) push_tick(1'b0);
        push_tick(1'b1);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic random_phase(input int cpr_val, input int rate_val);
        int start_ticks;
        int start_caps;
        int gap;
        logic [CFG_W-1:0] cpr_word;
        cpr_word = CFG_W'($urandom() & 32'h00FF_E000) | CFG_W'(cpr_val);
        write_reg(CFG_PULSES_PER_REV, cpr_word);
        write_reg(CFG_TICK_RATE_HZ, CFG_W'(rate_val));
        start_ticks = ticks_sent;
        start_caps = sb.captures;
        while (ticks_sent - start_ticks < 80 || sb.captures - start_caps < 6)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                gap = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 120)
                                                    : $urandom_range(0, 16);
                run_interval(gap);
                repeat ($urandom_range(0, 3)) push_tick(1'b0);
            end
            else
            begin
                // noise: edges at random, often leaving a measurement half done
                repeat ($urandom_range(1, 10)) push_tick($urandom_range(0, 2) == 0);
            end
        end
    endtask

    initial
    begin
        sb = new();
        idle_on = 1'b0;
        ticks_sent = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_PULSES_PER_REV;
        cfg_data <= '0;
        in_valid <= 1'b0;
        edge_req <= 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ticks while not measuring, then shortest interval
        push_tick(1'b0);
        push_tick(1'b0);
        run_interval(0);
        idle_on = 1'b1;
        run_interval(3);
        run_interval(9);

        // zero counts per revolution via masked upper bits
        write_reg(CFG_PULSES_PER_REV, 24'hFFE000);
        run_interval(5);
        write_reg(CFG_PULSES_PER_REV, 24'd200);
        write_reg(CFG_TICK_RATE_HZ, 24'd0);
        run_interval(2);

        random_phase(200, 4000000);
        random_phase(1, 16000000);
        random_phase(4096, 1);
        random_phase(8191, 24'hFFFFFF);
        random_phase($urandom_range(1, 4096), $urandom_range(1, 16000000));
        idle_on = 1'b0;
        random_phase($urandom_range(1, 4096), $urandom_range(1, 16000000));

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (40) @(negedge clk);

        $display("%0d ticks driven, %0d speed items checked (%0d saturated, %0d after a wrap)",
                 ticks_sent, sb.checked, sb.sat_seen, sb.wrap_count);
        $display("%0d register writes, counts and rates from zero to all ones",
                 sb.reg_writes);
        if (sb.errors == 0)
            $display("encoder_period_speed_estimator_top verification clean");
        else
            $display("encoder_period_speed_estimator_top verification failed");
        $finish;
    end

endmodule
